// ----- sv/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper package
// Beat types, the run descriptor that passes from the front to the back, and
// the character constants that both halves use.
// ----------------------------------------------------------------------------
package jse_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CTRL_LIMIT = 8'd32;

   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_FF  = 8'd12;
   localparam logic [7:0] CODE_CR  = 8'd13;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_CLOSE,
      KIND_PLAIN,
      KIND_PAIR,
      KIND_UNI
   } kind_type;

   typedef struct packed {
      logic       open_quote;
      kind_type   kind;
      logic [7:0] ch;
   } run_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CH_ZERO + {4'b0000, nib};
      end
      return 8'h57 + {4'b0000, nib};
   endfunction

endpackage

// ----- sv/json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns a stream of string bytes into the characters of a JSON string literal.
//
// The request channel (req_valid, req_stall, req_data) takes one beat per
// string byte, or an end-of-string beat. The response channel (rsp_valid,
// rsp_stall, rsp_data) gives one character per beat; run_end marks the last
// character caused by a request beat. Each request causes 1 to 7 characters:
// an opening quote before the first beat of a string, the byte or its escape,
// and the closing quote on the end beat.
// The queue and then the output register lie between a request beat and its
// first character. The back end emits one character per cycle while rsp_stall
// is low, so plain bytes sustain one request beat per cycle; an escaped byte
// occupies the back end until all its characters are out. Up to QueueDepth
// runs wait in the queue, and req_stall rises only when that queue is full.
// A stalled response beat holds; the back end then stops and the queue fills.
// Reset closes any open string and empties the queue and output register.
// ----------------------------------------------------------------------------
module json_string_escaper
   import jse_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push;
   run_type push_run;
   logic    queue_full;
   logic    pop;
   run_type head;
   logic    empty;

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_run   (push_run)
   );

   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/jse_front.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input beats, classifies each byte and tracks whether a string is
// open, then writes one run descriptor per beat into the queue.
// ----------------------------------------------------------------------------
module jse_front
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push,
   output run_type push_run
);

   logic inside_ff;
   logic inside_in;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_run.open_quote = !inside_ff;
      push_run.ch         = req_data.ch;
      push_run.kind       = KIND_PLAIN;
      if (req_data.op == OP_END) begin
         push_run.kind = KIND_CLOSE;
      end else begin
         case (req_data.ch)
            CODE_BS: begin
               push_run.kind = KIND_PAIR;
               push_run.ch   = CH_B;
            end
            CODE_TAB: begin
               push_run.kind = KIND_PAIR;
               push_run.ch   = CH_T;
            end
            CODE_LF: begin
               push_run.kind = KIND_PAIR;
               push_run.ch   = CH_N;
            end
            CODE_FF: begin
               push_run.kind = KIND_PAIR;
               push_run.ch   = CH_F;
            end
            CODE_CR: begin
               push_run.kind = KIND_PAIR;
               push_run.ch   = CH_R;
            end
            CH_QUOTE, CH_BSLASH: begin
               push_run.kind = KIND_PAIR;
            end
            default: begin
               if (req_data.ch < CTRL_LIMIT) begin
                  push_run.kind = KIND_UNI;
               end
            end
         endcase
      end
   end

   assign inside_in = push ? (req_data.op == OP_DATA) : inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

endmodule

// ----- sv/jse_queue.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper run queue
// A small first-in first-out store of run descriptors between the front and
// the back, with the head entry visible for the back to step through.
// ----------------------------------------------------------------------------
module jse_queue
   import jse_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   output logic    full,
   input  logic    pop,
   output run_type head,
   output logic    empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   run_type           store_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full  = (count_ff == FullCnt);
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_run;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCnt)
      else $error("Run queue holds more entries than it has room for.");

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Run pushed into a full queue.");

   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("Run popped from an empty queue.");

endmodule

// ----- sv/jse_back.sv -----
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Steps through the characters of the head run, one per cycle unless stalled,
// into the output register, and pops the run as its last character loads.
// ----------------------------------------------------------------------------
module jse_back
   import jse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  run_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] body_idx;
   logic [2:0] run_len;
   logic       last;
   logic       load;
   logic [7:0] cur_char;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   always_comb begin
      case (head.kind)
         KIND_CLOSE: run_len = 3'd1;
         KIND_PLAIN: run_len = 3'd1;
         KIND_PAIR:  run_len = 3'd2;
         KIND_UNI:   run_len = 3'd6;
         default:    run_len = 3'd1;
      endcase
      run_len = run_len + {2'b00, head.open_quote};
   end

   assign body_idx = idx_ff - {2'b00, head.open_quote};
   assign last     = (idx_ff == run_len - 3'd1);

   always_comb begin
      cur_char = CH_QUOTE;
      if (!(head.open_quote && idx_ff == 3'd0)) begin
         case (head.kind)
            KIND_CLOSE: cur_char = CH_QUOTE;
            KIND_PLAIN: cur_char = head.ch;
            KIND_PAIR:  cur_char = (body_idx == 3'd0) ? CH_BSLASH : head.ch;
            KIND_UNI: begin
               case (body_idx)
                  3'd0:    cur_char = CH_BSLASH;
                  3'd1:    cur_char = CH_U;
                  3'd4:    cur_char = hex_char(head.ch[7:4]);
                  3'd5:    cur_char = hex_char(head.ch[3:0]);
                  default: cur_char = CH_ZERO;
               endcase
            end
            default: cur_char = CH_QUOTE;
         endcase
      end
   end

   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && !empty && last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = !empty;
         if (!empty) begin
            rsp_data_in.out_char = cur_char;
            rsp_data_in.run_end  = last;
            idx_in               = last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) empty |-> idx_ff == 3'd0)
      else $error("Character index left mid-run with no run queued.");

   assert property (@(posedge clock) disable iff (reset) !empty |-> idx_ff < run_len)
      else $error("Character index ran past the end of the run.");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("Stalled response beat changed or was dropped.");

endmodule
